// ===== sv/two_queues_shared_buffer_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TWO_QUEUES_SHARED_BUFFER_MACROS_SVH
`define TWO_QUEUES_SHARED_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TQSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TQSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tqsb_pkg.sv =====
// Package: codes, widths, types and defaults of the two-queue shared buffer.
package tqsb_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int DATA_W        = 32;

	localparam logic [OP_W-1:0] OP_ENQ_ONE = 2'd0;
	localparam logic [OP_W-1:0] OP_ENQ_TWO = 2'd1;
	localparam logic [OP_W-1:0] OP_DEQ_ONE = 2'd2;
	localparam logic [OP_W-1:0] OP_DEQ_TWO = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic capture;
	} tqsb_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
	} tqsb_stat_t;

endpackage

// ===== sv/tqsb_cmd_if.sv =====
// Interface: input channel carrying one queue operation per transfer.
interface tqsb_cmd_if
	import tqsb_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

// ===== sv/tqsb_result_if.sv =====
// Interface: output channel carrying one result per transfer.
interface tqsb_result_if
	import tqsb_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] data;

	modport source (output valid, output status, output data, input ready);
	modport sink (input valid, input status, input data, output ready);
endinterface

// ===== sv/two_queues_shared_buffer.sv =====
// Two FIFO queues in one shared buffer; top level.
// Queue one grows upward from entry 0 and queue two downward from entry DEPTH-1 of one
// DEPTH-word RAM. One operation is handled at a time. An enqueue, an overflow or an
// underflow is answered on the result channel the cycle after its transfer; a dequeue
// that succeeds passes the registered read port of the RAM, then the result register. A
// new operation is taken while an earlier result still waits, as long as that result is
// taken in the same cycle. Storage is not cleared at reset; only written entries are read.
module two_queues_shared_buffer
	import tqsb_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tqsb_cmd_if.sink      cmd,
	tqsb_result_if.source result
);

	tqsb_ctl_t  ctl;
	tqsb_stat_t stat;

	tqsb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_ready    (cmd.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.ctl          (ctl)
	);

	tqsb_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cmd.op),
		.value  (cmd.value),
		.status (result.status),
		.data   (result.data),
		.ctl    (ctl),
		.stat   (stat)
	);

endmodule

// ===== sv/tqsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tqsb_ram
	import tqsb_pkg::*;
#(
	parameter int WIDTH = WORD_BITS_DEF,
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tqsb_ctrl.sv =====
// Controller: accept/read sequencing and result valid flag.
module tqsb_ctrl
	import tqsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  tqsb_stat_t stat,
	output tqsb_ctl_t  ctl
);

	state_t state_q, state_d;
	logic   valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (ctl.accept && stat.is_read) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_ready   = 1'b0;
		ctl.capture = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_ready = !valid_q || result_ready;
			end
			S_READ: begin
				ctl.capture = 1'b1;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
		ctl.accept = cmd_valid && cmd_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((ctl.accept && !stat.is_read) || ctl.capture) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;

endmodule

// ===== sv/tqsb_dp.sv =====
// Datapath: queue pointers, shared storage and result register.
module tqsb_dp
	import tqsb_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [OP_W-1:0]            op,
	input  logic signed [DATA_W-1:0]   value,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   data,
	input  tqsb_ctl_t                  ctl,
	output tqsb_stat_t                 stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

	// queue one pointers are offset by one: zero means empty
	logic [PW-1:0] hu_q, tu_q, hd_q, td_q;
	logic [PW-1:0] hu_d, tu_d, hd_d, td_d;
	logic [PW-1:0] hu_inc, hu_dec, tu_inc, hd_dec, td_dec;
	logic          full, empty_one, empty_two;
	logic          wr, rd;
	logic [STATUS_W-1:0] st;
	logic [AW-1:0]       waddr, raddr;
	logic [WORD_BITS-1:0] wdata, rdata;
	logic [STATUS_W-1:0]      status_q;
	logic signed [DATA_W-1:0] data_q;

	assign wdata = WORD_BITS'($unsigned(value));

	always_comb begin
		full      = (tu_q == td_q);
		empty_one = (hu_q == '0) || (hu_q > tu_q);
		empty_two = (hd_q == DEPTH_P) || (hd_q < td_q);
		hu_inc    = hu_q + PW'(1);
		hu_dec    = hu_q - PW'(1);
		tu_inc    = tu_q + PW'(1);
		hd_dec    = hd_q - PW'(1);
		td_dec    = td_q - PW'(1);
		st        = ST_OK;
		wr        = 1'b0;
		rd        = 1'b0;
		waddr     = tu_q[AW-1:0];
		raddr     = hd_q[AW-1:0];
		hu_d      = hu_q;
		tu_d      = tu_q;
		hd_d      = hd_q;
		td_d      = td_q;
		case (op)
			OP_ENQ_ONE: begin
				waddr = tu_q[AW-1:0];
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					wr   = 1'b1;
					tu_d = tu_inc;
					if (hu_q == '0) begin
						hu_d = PW'(1);
					end
				end
			end
			OP_ENQ_TWO: begin
				waddr = td_dec[AW-1:0];
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					wr   = 1'b1;
					td_d = td_dec;
					if (hd_q == DEPTH_P) begin
						hd_d = DEPTH_P - PW'(1);
					end
				end
			end
			OP_DEQ_ONE: begin
				raddr = hu_dec[AW-1:0];
				if (empty_one) begin
					st = ST_UNDERFLOW;
				end else begin
					rd = 1'b1;
					if (hu_q >= tu_q) begin
						hu_d = '0;
						tu_d = '0;
					end else begin
						hu_d = hu_inc;
					end
				end
			end
			OP_DEQ_TWO: begin
				raddr = hd_q[AW-1:0];
				if (empty_two) begin
					st = ST_UNDERFLOW;
				end else begin
					rd = 1'b1;
					if (hd_q <= td_q) begin
						hd_d = DEPTH_P;
						td_d = DEPTH_P;
					end else begin
						hd_d = hd_dec;
					end
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign stat.is_read = rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hu_q <= '0;
			tu_q <= '0;
			hd_q <= DEPTH_P;
			td_q <= DEPTH_P;
		end else if (ctl.accept) begin
			hu_q <= hu_d;
			tu_q <= tu_d;
			hd_q <= hd_d;
			td_q <= td_d;
		end
	end

	tqsb_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.accept && wr),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.accept && rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept && !rd) begin
			status_q <= st;
			data_q   <= '0;
		end else if (ctl.capture) begin
			status_q <= ST_OK;
			data_q   <= $signed(DATA_W'(rdata));
		end
	end

	assign status = status_q;
	assign data   = data_q;

endmodule

// ===== sv/tqsb_checker.sv =====
// Port-level checker for the two-queue shared buffer, with its bind.
`include "two_queues_shared_buffer_macros.svh"

module tqsb_checker
	import tqsb_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cmd_valid,
	input logic                     cmd_ready,
	input logic [OP_W-1:0]          cmd_op,
	input logic                     result_valid,
	input logic                     result_ready,
	input logic [STATUS_W-1:0]      result_status,
	input logic signed [DATA_W-1:0] result_data
);

	`TQSB_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped before transfer")
	`TQSB_ASSERT_NOW(a_status_code, clk, arst_n, result_valid, result_status == ST_OK || result_status == ST_OVERFLOW || result_status == ST_UNDERFLOW, "unknown status code")
	`TQSB_ASSERT_NOW(a_error_zero_data, clk, arst_n, result_valid && result_status != ST_OK, result_data == '0, "error result carries data")
	`TQSB_ASSERT_NEXT(a_enqueue_answer, clk, arst_n, cmd_valid && cmd_ready && (cmd_op == OP_ENQ_ONE || cmd_op == OP_ENQ_TWO), result_valid && result_status != ST_UNDERFLOW, "enqueue not answered next cycle")
	`TQSB_ASSERT_NOW(a_no_overrun, clk, arst_n, cmd_ready && result_valid, result_ready, "operation taken over a waiting result")

endmodule

bind two_queues_shared_buffer tqsb_checker u_tqsb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_op        (cmd.op),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_status (result.status),
	.result_data   (result.data)
);
